[hw/rtl/tlbpt_pkg.sv]
// Shared types and constants for the TLB and page table translator.
`timescale 1ns / 1ps
`default_nettype none
package tlbpt_pkg;

    localparam int ADDR_W           = 16;
    localparam int CNT_W            = 16;
    localparam int DEF_TLB_ENTRIES  = 16;
    localparam int DEF_OFFSET_BITS  = 8;
    localparam int DEF_PAGE_BITS    = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // output tuser bit positions
    localparam int TUSER_HIT   = 0;
    localparam int TUSER_FAULT = 1;
    localparam int TUSER_W     = 2;
    // output tdata: physical address, hit total, fault total
    localparam int M_TDATA_W   = ADDR_W + 2 * CNT_W;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_LOOK = 1'b1
    } t_state;

    // page table control from the sequencer
    typedef struct packed {
        logic rd_en;     // capture present bit and frame for the incoming page
        logic alloc_en;  // commit a fault: mark page present, hand out next frame
    } t_pt_ctrl;

endpackage
`default_nettype wire

[hw/rtl/tlb_page_table_translator.sv]
// Top level: TLB with recency order, demand-paged page table, output register.
//
// Translates a 16-bit logical address into a physical address.
// Input stream (s_axis): tdata carries the logical address; page is the
// PAGE_BITS above the OFFSET_BITS offset.
// Output stream (m_axis): tdata carries physical address, hit total and
// fault total; tuser carries the TLB hit and page fault flags.
// On accept a request reads the page table memory (registered read port);
// the lookup state then compares the page against all TLB slots at once,
// resolves the frame and shifts the slot row.
// One request is in flight at a time: a new request is taken only once the
// last one has left the lookup state.
// The result sits in an output register; the next request is taken while it
// waits. If the receiver stalls, the second request holds in its lookup cycle
// until the output register frees up, and the input stays not ready.
// Reset clears the TLB valid bits, the page present bits, the frame
// allocator and both counters together; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module tlb_page_table_translator #(
    parameter int TLB_ENTRIES = tlbpt_pkg::DEF_TLB_ENTRIES,
    parameter int OFFSET_BITS = tlbpt_pkg::DEF_OFFSET_BITS,
    parameter int PAGE_BITS   = tlbpt_pkg::DEF_PAGE_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // [15:0] logical_address
    input  wire logic [tlbpt_pkg::ADDR_W-1:0]        i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // [15:0] physical_address, [31:16] hit_total, [47:32] fault_total
    output logic [tlbpt_pkg::M_TDATA_W-1:0]          o_m_axis_tdata,
    // [0] tlb_hit, [1] page_fault
    output logic [tlbpt_pkg::TUSER_W-1:0]            o_m_axis_tuser
);

    localparam int ADDR_W = tlbpt_pkg::ADDR_W;
    localparam int CNT_W  = tlbpt_pkg::CNT_W;
    localparam int EXT_W  = ADDR_W + PAGE_BITS;
    localparam int PHYS_W = ADDR_W + PAGE_BITS + OFFSET_BITS;

    tlbpt_pkg::t_state   r_state;
    tlbpt_pkg::t_state   n_state;
    tlbpt_pkg::t_pt_ctrl w_pt_ctrl;

    logic                     w_accept;
    logic                     w_commit;
    logic [EXT_W-1:0]         w_in_ext;
    logic [PAGE_BITS-1:0]     w_in_page;
    logic [ADDR_W-1:0]        r_addr;
    logic [EXT_W-1:0]         w_addr_ext;
    logic [PAGE_BITS-1:0]     w_page;
    logic [OFFSET_BITS-1:0]   w_offset;

    logic                     w_tlb_hit;
    logic [PAGE_BITS-1:0]     w_tlb_frame;
    logic                     w_present;
    logic [PAGE_BITS-1:0]     w_pt_frame;
    logic [PAGE_BITS-1:0]     w_alloc_frame;
    logic                     w_fault;
    logic [PAGE_BITS-1:0]     w_frame;
    logic [PHYS_W-1:0]        w_phys_ext;

    logic                     r_out_valid;
    logic [ADDR_W-1:0]        r_phys;
    logic                     r_hit;
    logic                     r_fault;
    logic [CNT_W-1:0]         r_hit_cnt;
    logic [CNT_W-1:0]         r_fault_cnt;

    // page/offset split, zero above the 16-bit address
    assign w_in_ext   = {{PAGE_BITS{1'b0}}, i_s_axis_tdata};
    assign w_in_page  = w_in_ext[OFFSET_BITS +: PAGE_BITS];
    assign w_addr_ext = {{PAGE_BITS{1'b0}}, r_addr};
    assign w_page     = w_addr_ext[OFFSET_BITS +: PAGE_BITS];
    assign w_offset   = r_addr[OFFSET_BITS-1:0];

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            tlbpt_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) n_state = tlbpt_pkg::S_LOOK;
            end
            tlbpt_pkg::S_LOOK: begin
                if (!r_out_valid || i_m_axis_tready) n_state = tlbpt_pkg::S_IDLE;
            end
            default: n_state = tlbpt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        w_commit        = 1'b0;
        case (r_state)
            tlbpt_pkg::S_IDLE: o_s_axis_tready = 1'b1;
            tlbpt_pkg::S_LOOK: w_commit = !r_out_valid || i_m_axis_tready;
            default: begin
                o_s_axis_tready = 1'b0;
                w_commit        = 1'b0;
            end
        endcase
    end

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlbpt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr <= i_s_axis_tdata;
        end
    end

    // frame resolution
    assign w_fault  = !w_tlb_hit && !w_present;
    assign w_frame  = w_tlb_hit ? w_tlb_frame : (w_present ? w_pt_frame : w_alloc_frame);

    assign w_pt_ctrl.rd_en    = w_accept;
    assign w_pt_ctrl.alloc_en = w_commit && w_fault;

    tlbpt_page_table #(
        .PAGE_BITS(PAGE_BITS)
    ) u_page_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_pt_ctrl),
        .i_rd_page    (w_in_page),
        .i_wr_page    (w_page),
        .o_present    (w_present),
        .o_frame      (w_pt_frame),
        .o_alloc_frame(w_alloc_frame)
    );

    tlbpt_chain #(
        .TLB_ENTRIES(TLB_ENTRIES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_lookup_page(w_page),
        .i_update     (w_commit),
        .i_new_frame  (w_frame),
        .o_hit        (w_tlb_hit),
        .o_hit_frame  (w_tlb_frame)
    );

    assign w_phys_ext = {{ADDR_W{1'b0}}, w_frame, w_offset};

    // counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hit_cnt   <= '0;
            r_fault_cnt <= '0;
        end else begin
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_commit && w_tlb_hit && (r_hit_cnt != tlbpt_pkg::CNT_MAX)) begin
                r_hit_cnt <= r_hit_cnt + 1'b1;
            end
            if (w_commit && w_fault && (r_fault_cnt != tlbpt_pkg::CNT_MAX)) begin
                r_fault_cnt <= r_fault_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_phys  <= w_phys_ext[ADDR_W-1:0];
            r_hit   <= w_tlb_hit;
            r_fault <= w_fault;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_fault_cnt, r_hit_cnt, r_phys};
    always_comb begin
        o_m_axis_tuser                        = '0;
        o_m_axis_tuser[tlbpt_pkg::TUSER_HIT]   = r_hit;
        o_m_axis_tuser[tlbpt_pkg::TUSER_FAULT] = r_fault;
    end

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(r_hit && r_fault))
        else $error("hit and fault flagged together");

    a_accept_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == tlbpt_pkg::S_LOOK) && !o_s_axis_tready)
        else $error("accepted request did not enter lookup");

    a_commit_gives_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> o_m_axis_tvalid)
        else $error("committed result not presented");

    a_fault_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && w_fault) |=>
            (r_fault_cnt == $past(r_fault_cnt) + 1'b1) ||
            (r_fault_cnt == tlbpt_pkg::CNT_MAX))
        else $error("fault counter did not advance");
`endif

endmodule
`default_nettype wire

[hw/rtl/tlbpt_cell.sv]
// One TLB slot: holds a page/frame pair and passes it to the next older slot.
`timescale 1ns / 1ps
`default_nettype none
module tlbpt_cell #(
    parameter int PAGE_BITS = tlbpt_pkg::DEF_PAGE_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [PAGE_BITS-1:0] i_lookup_page,
    input  wire logic                 i_update,
    input  wire logic                 i_any_hit,
    input  wire logic                 i_seen_in,     // hit somewhere in an older slot
    input  wire logic                 i_prev_valid,  // neighbor on the newer side
    input  wire logic [PAGE_BITS-1:0] i_prev_page,
    input  wire logic [PAGE_BITS-1:0] i_prev_frame,
    output logic                      o_valid,
    output logic [PAGE_BITS-1:0]      o_page,
    output logic [PAGE_BITS-1:0]      o_frame,
    output logic                      o_seen_out,
    output logic [PAGE_BITS-1:0]      o_hit_frame
);

    logic                 r_valid;
    logic [PAGE_BITS-1:0] r_page;
    logic [PAGE_BITS-1:0] r_frame;
    logic                 w_match;
    logic                 w_shift;

    assign w_match     = r_valid && (r_page == i_lookup_page);
    assign o_seen_out  = i_seen_in | w_match;
    // a miss shifts every slot; a hit shifts only the slots from the newest down to it
    assign w_shift     = i_update && (!i_any_hit || o_seen_out);
    assign o_hit_frame = w_match ? r_frame : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_shift) begin
            r_valid <= i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_page  <= i_prev_page;
            r_frame <= i_prev_frame;
        end
    end

    assign o_valid = r_valid;
    assign o_page  = r_page;
    assign o_frame = r_frame;

endmodule
`default_nettype wire

[hw/rtl/tlbpt_chain.sv]
// Row of TLB slots, newest at slot 0, oldest at the far end.
`timescale 1ns / 1ps
`default_nettype none
module tlbpt_chain #(
    parameter int TLB_ENTRIES = tlbpt_pkg::DEF_TLB_ENTRIES,
    parameter int PAGE_BITS   = tlbpt_pkg::DEF_PAGE_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [PAGE_BITS-1:0] i_lookup_page,
    input  wire logic                 i_update,
    input  wire logic [PAGE_BITS-1:0] i_new_frame,
    output logic                      o_hit,
    output logic [PAGE_BITS-1:0]      o_hit_frame
);

    logic                 w_valid     [TLB_ENTRIES];
    logic [PAGE_BITS-1:0] w_page      [TLB_ENTRIES];
    logic [PAGE_BITS-1:0] w_frame     [TLB_ENTRIES];
    logic                 w_prev_valid[TLB_ENTRIES];
    logic [PAGE_BITS-1:0] w_prev_page [TLB_ENTRIES];
    logic [PAGE_BITS-1:0] w_prev_frame[TLB_ENTRIES];
    logic [PAGE_BITS-1:0] w_hit_frame [TLB_ENTRIES];
    logic                 w_seen      [TLB_ENTRIES+1];

    // hit search ripples from the oldest slot toward the newest
    assign w_seen[TLB_ENTRIES] = 1'b0;

    for (genvar k = 0; k < TLB_ENTRIES; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_prev_valid[k] = 1'b1;
            assign w_prev_page[k]  = i_lookup_page;
            assign w_prev_frame[k] = i_new_frame;
        end else begin : g_body
            assign w_prev_valid[k] = w_valid[k-1];
            assign w_prev_page[k]  = w_page[k-1];
            assign w_prev_frame[k] = w_frame[k-1];
        end

        tlbpt_cell #(
            .PAGE_BITS(PAGE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_lookup_page(i_lookup_page),
            .i_update     (i_update),
            .i_any_hit    (w_seen[0]),
            .i_seen_in    (w_seen[k+1]),
            .i_prev_valid (w_prev_valid[k]),
            .i_prev_page  (w_prev_page[k]),
            .i_prev_frame (w_prev_frame[k]),
            .o_valid      (w_valid[k]),
            .o_page       (w_page[k]),
            .o_frame      (w_frame[k]),
            .o_seen_out   (w_seen[k]),
            .o_hit_frame  (w_hit_frame[k])
        );
    end

    // at most one slot matches, so OR gives its frame
    always_comb begin
        o_hit_frame = '0;
        for (int k = 0; k < TLB_ENTRIES; k++) begin
            o_hit_frame = o_hit_frame | w_hit_frame[k];
        end
    end

    assign o_hit = w_seen[0];

endmodule
`default_nettype wire

[hw/rtl/tlbpt_page_table.sv]
// Page table: present bits, frame memory and in-order frame allocator.
`timescale 1ns / 1ps
`default_nettype none
module tlbpt_page_table #(
    parameter int PAGE_BITS = tlbpt_pkg::DEF_PAGE_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire tlbpt_pkg::t_pt_ctrl  i_ctrl,
    input  wire logic [PAGE_BITS-1:0] i_rd_page,
    input  wire logic [PAGE_BITS-1:0] i_wr_page,
    output logic                      o_present,
    output logic [PAGE_BITS-1:0]      o_frame,
    output logic [PAGE_BITS-1:0]      o_alloc_frame
);

    localparam int NUM_PAGES = 1 << PAGE_BITS;
    localparam logic [PAGE_BITS:0] FRAME_LIMIT = {1'b1, {PAGE_BITS{1'b0}}};

    logic                 r_present_bits[NUM_PAGES];
    logic [PAGE_BITS-1:0] r_frame_mem   [NUM_PAGES];
    logic                 r_present;
    logic [PAGE_BITS-1:0] r_frame;
    logic [PAGE_BITS:0]   r_next_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PAGES; p++) begin
                r_present_bits[p] <= 1'b0;
            end
        end else if (i_ctrl.alloc_en) begin
            r_present_bits[i_wr_page] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free <= '0;
        end else if (i_ctrl.alloc_en && (r_next_free != FRAME_LIMIT)) begin
            r_next_free <= r_next_free + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.alloc_en) begin
            r_frame_mem[i_wr_page] <= r_next_free[PAGE_BITS-1:0];
        end
        if (i_ctrl.rd_en) begin
            r_frame   <= r_frame_mem[i_rd_page];
            r_present <= r_present_bits[i_rd_page];
        end
    end

    assign o_present     = r_present;
    assign o_frame       = r_frame;
    assign o_alloc_frame = r_next_free[PAGE_BITS-1:0];

endmodule
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the TLB and page table translator.
`timescale 1ns / 1ps
module testbench;

    localparam int ADDR_W       = tlbpt_pkg::ADDR_W;
    localparam int CNT_W        = tlbpt_pkg::CNT_W;
    localparam int M_TDATA_W    = tlbpt_pkg::M_TDATA_W;
    localparam int TUSER_W      = tlbpt_pkg::TUSER_W;
    localparam int TUSER_HIT    = tlbpt_pkg::TUSER_HIT;
    localparam int TUSER_FAULT  = tlbpt_pkg::TUSER_FAULT;
    localparam logic [CNT_W-1:0] CNT_MAX = tlbpt_pkg::CNT_MAX;
    localparam int TLB_DEPTH    = tlbpt_pkg::DEF_TLB_ENTRIES;
    localparam int OFF_W        = tlbpt_pkg::DEF_OFFSET_BITS;
    localparam int PG_W         = tlbpt_pkg::DEF_PAGE_BITS;
    localparam int NUM_PAGES    = 1 << PG_W;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RECENT_DEPTH = 24;

    typedef struct {
        logic [ADDR_W-1:0] phys;
        logic              hit;
        logic              fault;
        logic [CNT_W-1:0]  hits;
        logic [CNT_W-1:0]  faults;
    } t_xlat;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [ADDR_W-1:0]    i_s_axis_tdata = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic [TUSER_W-1:0]   o_m_axis_tuser;

    tlb_page_table_translator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),  // [15:0] logical_address
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [15:0] phys, [31:16] hits, [47:32] faults
        .o_m_axis_tuser  (o_m_axis_tuser)   // [0] tlb_hit, [1] page_fault
    );

    always #5 i_clk = ~i_clk;

    // translation state mirrored from the block
    logic [PG_W-1:0]  tlb_pg [TLB_DEPTH];
    logic [PG_W-1:0]  tlb_frm[TLB_DEPTH];
    int               tlb_count = 0;
    bit               pt_present[NUM_PAGES];
    logic [PG_W-1:0]  pt_frame[NUM_PAGES];
    int               free_frame = 0;
    logic [CNT_W-1:0] hit_count = '0;
    logic [CNT_W-1:0] fault_count = '0;

    t_xlat pending_xlat[$];
    int    fail_count = 0;
    int    cycle_count = 0;

    // sender / receiver pacing
    bit tx_gaps_en = 1'b0;
    int burst_left = 0;
    bit rx_stall_en = 1'b0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int rx_left = 0;
    bit rx_ready_phase = 1'b1;

    // move entry at slot to the newest end, sliding the younger ones down
    function automatic void promote_entry(input int slot, input logic [PG_W-1:0] page,
                                          input logic [PG_W-1:0] frame);
        int k;
        for (k = slot; k + 1 < tlb_count; k++) begin
            tlb_pg[k]  = tlb_pg[k + 1];
            tlb_frm[k] = tlb_frm[k + 1];
        end
        if (tlb_count > 0) begin
            tlb_pg[tlb_count - 1]  = page;
            tlb_frm[tlb_count - 1] = frame;
        end
    endfunction

    function automatic t_xlat translate_address(input logic [ADDR_W-1:0] addr);
        logic [PG_W-1:0]  page;
        logic [OFF_W-1:0] offset;
        logic [PG_W-1:0]  frame;
        int               slot;
        int               k;
        bit               hit;
        bit               fault;
        t_xlat            r;
        page   = addr[OFF_W +: PG_W];
        offset = addr[OFF_W-1:0];
        frame  = '0;
        slot   = 0;
        hit    = 1'b0;
        fault  = 1'b0;
        for (k = 0; k < tlb_count; k++) begin
            if (!hit && tlb_pg[k] == page) begin
                hit   = 1'b1;
                slot  = k;
                frame = tlb_frm[k];
            end
        end
        if (hit) begin
            if (hit_count != CNT_MAX) hit_count++;
            promote_entry(slot, page, frame);
        end else begin
            if (pt_present[page]) begin
                frame = pt_frame[page];
            end else begin
                fault            = 1'b1;
                frame            = free_frame[PG_W-1:0];
                pt_present[page] = 1'b1;
                pt_frame[page]   = frame;
                if (free_frame < NUM_PAGES) free_frame++;
                if (fault_count != CNT_MAX) fault_count++;
            end
            if (tlb_count < TLB_DEPTH) begin
                tlb_pg[tlb_count]  = page;
                tlb_frm[tlb_count] = frame;
                tlb_count++;
            end else begin
                promote_entry(0, page, frame);
            end
        end
        r.phys   = {frame, offset};
        r.hit    = hit;
        r.fault  = fault;
        r.hits   = hit_count;
        r.faults = fault_count;
        return r;
    endfunction

    // one request; the prediction is made at the accepting edge
    task automatic send_address(input logic [ADDR_W-1:0] addr);
        if (tx_gaps_en && burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= addr;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_xlat.push_back(translate_address(addr));
        if (burst_left > 0) burst_left--;
    endtask

    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served     <= hold_requests;
            hold_left       <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!rx_stall_en) begin
            i_m_axis_tready <= 1'b1;
        end else if (rx_left == 0) begin
            rx_ready_phase  <= !rx_ready_phase;
            rx_left         <= rx_ready_phase ? $urandom_range(1, 8) : $urandom_range(1, 12);
            i_m_axis_tready <= !rx_ready_phase;
        end else begin
            rx_left         <= rx_left - 1;
            i_m_axis_tready <= rx_ready_phase;
        end
    end

    always @(posedge i_clk) begin : check_result
        t_xlat want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_xlat.size() == 0) begin
                $error("result with no request outstanding: tdata %h tuser %b",
                       o_m_axis_tdata, o_m_axis_tuser);
                fail_count++;
            end else begin
                want = pending_xlat.pop_front();
                if (o_m_axis_tdata[ADDR_W-1:0] !== want.phys) begin
                    $error("physical_address: expected %h, got %h",
                           want.phys, o_m_axis_tdata[ADDR_W-1:0]);
                    fail_count++;
                end
                if (o_m_axis_tuser[TUSER_HIT] !== want.hit) begin
                    $error("tlb_hit: expected %b, got %b", want.hit, o_m_axis_tuser[TUSER_HIT]);
                    fail_count++;
                end
                if (o_m_axis_tuser[TUSER_FAULT] !== want.fault) begin
                    $error("page_fault: expected %b, got %b",
                           want.fault, o_m_axis_tuser[TUSER_FAULT]);
                    fail_count++;
                end
                if (o_m_axis_tdata[ADDR_W +: CNT_W] !== want.hits) begin
                    $error("hit_total: expected %h, got %h",
                           want.hits, o_m_axis_tdata[ADDR_W +: CNT_W]);
                    fail_count++;
                end
                if (o_m_axis_tdata[ADDR_W + CNT_W +: CNT_W] !== want.faults) begin
                    $error("fault_total: expected %h, got %h",
                           want.faults, o_m_axis_tdata[ADDR_W + CNT_W +: CNT_W]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // address extremes, hit reordering, eviction and page table reloads
    task automatic test_directed();
        int p;
        tx_gaps_en  = 1'b1;
        rx_stall_en = 1'b1;
        send_address(16'h0000);
        send_address(16'h00FF);
        send_address(16'hFFFF);
        send_address(16'hFF00);
        for (p = 1; p <= 14; p++) send_address({p[PG_W-1:0], 8'($urandom_range(0, 255))});
        send_address(16'h0042);    // hit on the oldest entry, moves to newest
        send_address(16'h8011);    // miss on full TLB, evicts page FF
        send_address(16'hFF7E);    // evicted page: reload from page table, no fault
        send_address(16'h0133);    // page 1 was evicted too
        send_address(16'h80AA);
        send_address(16'h0001);
    endtask

    task automatic test_random_traffic(input int count, input bit idle_en);
        logic [PG_W-1:0]   recent[$];
        logic [PG_W-1:0]   page;
        logic [OFF_W-1:0]  offset;
        logic [ADDR_W-1:0] addr;
        int                sel;
        int                n;
        tx_gaps_en  = idle_en;
        rx_stall_en = idle_en;
        for (n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0:       offset = '0;
                1:       offset = '1;
                default: offset = OFF_W'($urandom_range(0, (1 << OFF_W) - 1));
            endcase
            if (sel < 55 && recent.size() > 0) begin
                page = recent[$urandom_range(0, recent.size() - 1)];
                addr = {page, offset};
            end else if (sel < 80) begin
                page = PG_W'($urandom_range(0, NUM_PAGES - 1));
                addr = {page, offset};
            end else begin
                addr = ADDR_W'($urandom_range(0, 16'hFFFF));
            end
            send_address(addr);
            recent.push_back(addr[OFF_W +: PG_W]);
            if (recent.size() > RECENT_DEPTH) void'(recent.pop_front());
        end
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        int n;
        tx_gaps_en  = 1'b0;
        rx_stall_en = 1'b0;
        hold_requests++;
        for (n = 0; n < 30; n++)
            send_address({4'h3, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255))});
    endtask

    // touch every page so the allocator hands out its last frame
    task automatic test_frame_exhaustion();
        int order[NUM_PAGES];
        int n;
        int j;
        int tmp;
        tx_gaps_en  = 1'b1;
        rx_stall_en = 1'b1;
        for (n = 0; n < NUM_PAGES; n++) order[n] = n;
        for (n = NUM_PAGES - 1; n > 0; n--) begin
            j        = $urandom_range(0, n);
            tmp      = order[n];
            order[n] = order[j];
            order[j] = tmp;
        end
        for (n = 0; n < NUM_PAGES; n++)
            send_address({order[n][PG_W-1:0], 8'($urandom_range(0, 255))});
        for (n = 0; n < 20; n++) send_address(ADDR_W'($urandom_range(0, 16'hFFFF)));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_traffic(250, 1'b1);
        test_random_traffic(100, 1'b0);
        test_backpressure();
        test_random_traffic(40, 1'b1);
        test_frame_exhaustion();
        i_s_axis_tvalid <= 1'b0;
        while (pending_xlat.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[tlb_page_table_translator.f]
hw/rtl/tlbpt_pkg.sv
hw/rtl/tlbpt_cell.sv
hw/rtl/tlbpt_chain.sv
hw/rtl/tlbpt_page_table.sv
hw/rtl/tlb_page_table_translator.sv
sim/testbench.sv
